/* design/tgr_pkg.sv */
package tgr_pkg;

   // Atlas geometry
   localparam int TILES_PER_SIDE = 16;
   localparam int MAX_TILE_SIZE  = 16;
   localparam int MIN_TILE_SIZE  = 3;
   localparam int PITCH          = TILES_PER_SIDE * MAX_TILE_SIZE;
   localparam int STORE_DEPTH    = PITCH * PITCH;

   // Field widths fixed by the interface
   localparam int POS_W = 8;
   localparam int PIX_W = 32;
   localparam int CFG_W = 5;
   localparam int CSR_IDX_W = 1;

   // Derived widths
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int SIZE_W = $clog2(MAX_TILE_SIZE + 1);
   localparam int LOC_W  = $clog2(MAX_TILE_SIZE);
   localparam int SRC_W  = $clog2(PITCH);
   localparam int IMG_W  = $clog2(PITCH + 1);
   localparam int CMP_W  = (IMG_W > POS_W) ? IMG_W : POS_W;

   // Reciprocal used for pos / size: exact for 8-bit pos and sizes up to 64
   localparam int RECIP_SH = 16;
   localparam int RECIP_W  = RECIP_SH + 1;

   // Register reset and indexes
   localparam logic [CFG_W-1:0]     CFG_RESET       = CFG_W'(16);
   localparam logic [CSR_IDX_W-1:0] REG_TILE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_TILE_HEIGHT = CSR_IDX_W'(1);

   // Request codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   // Stage load enables handed to the coordinate mappers
   typedef struct packed {
      logic st2;
      logic st3;
   } pipe_en_type;

endpackage

/* design/tgr_coord_map.sv */
module tgr_coord_map (
   input  logic                        clock,
   input  tgr_pkg::pipe_en_type        en,
   input  logic [tgr_pkg::POS_W-1:0]   pos,
   input  logic [tgr_pkg::SIZE_W-1:0]  size,
   output logic [tgr_pkg::SRC_W-1:0]   src,
   output logic                        in_range
);
   import tgr_pkg::*;

   // ceil(2^RECIP_SH / t), zero for an empty tile
   logic [RECIP_W-1:0] recip_tab [0:MAX_TILE_SIZE];
   // source offset per (size - 1, local coordinate)
   logic [LOC_W-1:0]   off_tab [0:MAX_TILE_SIZE-1][0:MAX_TILE_SIZE-1];

   for (genvar Ts = 0; Ts <= MAX_TILE_SIZE; Ts++) begin : g_recip
      if (Ts == 0) begin : g_zero
         assign recip_tab[Ts] = '0;
      end else begin : g_val
         localparam int Recip = ((1 << RECIP_SH) + Ts - 1) / Ts;
         assign recip_tab[Ts] = RECIP_W'(Recip);
      end
   end

   for (genvar Tm = 0; Tm < MAX_TILE_SIZE; Tm++) begin : g_off_t
      for (genvar Lc = 0; Lc < MAX_TILE_SIZE; Lc++) begin : g_off_l
         localparam int Tsz = Tm + 1;
         if (Tsz < MIN_TILE_SIZE) begin : g_narrow
            assign off_tab[Tm][Lc] = '0;
         end else begin : g_val
            localparam int Idx = (Lc == 0) ? 0 : Lc - 1;
            localparam int Icl = (Idx > Tsz - 3) ? Tsz - 3 : Idx;
            localparam int Off = (2 * Icl * Tsz + Tsz - 2) / (2 * (Tsz - 2));
            assign off_tab[Tm][Lc] = LOC_W'(Off);
         end
      end
   end

   // stage 2: tile index by reciprocal multiply, range check
   logic [POS_W+RECIP_W-1:0] prod;
   logic [POS_W-1:0]         q_in, q_ff, pos2_ff;
   logic                     inr_in, inr2_ff;

   assign prod   = pos * recip_tab[size];
   assign q_in   = prod[RECIP_SH +: POS_W];
   assign inr_in = CMP_W'(pos) < CMP_W'(CMP_W'(TILES_PER_SIDE) * CMP_W'(size));

   always_ff @(posedge clock) begin
      if (en.st2) begin
         q_ff    <= q_in;
         pos2_ff <= pos;
         inr2_ff <= inr_in;
      end
   end

   // stage 3: tile base and local coordinate
   logic [POS_W+SIZE_W-1:0] base_full;
   logic [POS_W-1:0]        base_in, base_ff, diff;
   logic [LOC_W-1:0]        loc_in, loc_ff;
   logic                    inr3_ff;

   assign base_full = q_ff * size;
   assign base_in   = base_full[POS_W-1:0];
   assign diff      = pos2_ff - base_in;
   assign loc_in    = diff[LOC_W-1:0];

   always_ff @(posedge clock) begin
      if (en.st3) begin
         base_ff <= base_in;
         loc_ff  <= loc_in;
         inr3_ff <= inr2_ff;
      end
   end

   // gutter offset lookup and source coordinate
   logic [SIZE_W-1:0] size_m1;
   logic [LOC_W-1:0]  off_val;

   assign size_m1  = size - SIZE_W'(1);
   assign off_val  = off_tab[size_m1[LOC_W-1:0]][loc_ff];
   assign src      = SRC_W'(base_ff) + SRC_W'(off_val);
   assign in_range = inr3_ff;

endmodule

/* design/tile_gutter_resampler_unit.sv */
// Tile gutter resampler. Holds a 256 x 256 RGBA source atlas of 16 x 16 tiles in
// one synchronous RAM (one write and one read port). Loads (req_type = 0) write
// a pixel at (pos_x, pos_y) when it lies in the configured image and produce no
// item on rsp_. Fetches (req_type = 1) return one item: the pixel of the
// gutter-fixed atlas, where each tile is shrunk by two pixels and ringed with a
// one-pixel copy of its edge. Out-of-image fetches return bad_coord = 1 and zero;
// tiles narrower than three pixels return zero. The block is a four-stage pipeline
// that takes one item per clock while rsp_stall is low. Each stage moves on
// whenever the stage ahead is empty or moving, so bubbles collapse and intake
// continues while a result waits. Loads and fetches hit the RAM in the same stage
// and in order, so a fetch always sees every earlier load. The user must write
// tile sizes through csr_ (index 0 width, index 1 height, values above 16 act as
// 16) only while the block is idle; the block itself does not enforce this.
// Reading an atlas entry that was never loaded returns unspecified data.
module tile_gutter_resampler_unit (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_type,
   input  logic [tgr_pkg::POS_W-1:0]      req_pos_x,
   input  logic [tgr_pkg::POS_W-1:0]      req_pos_y,
   input  logic [tgr_pkg::PIX_W-1:0]      req_pixel_in,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tgr_pkg::PIX_W-1:0]      rsp_pixel_out,
   output logic                           rsp_bad_coord,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tgr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tgr_pkg::CFG_W-1:0]      csr_data
);
   import tgr_pkg::*;

   // ---------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------
   logic [CFG_W-1:0] tile_width_ff, tile_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff  <= CFG_RESET;
         tile_height_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TILE_WIDTH:  tile_width_ff  <= csr_data;
            REG_TILE_HEIGHT: tile_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // sizes above the maximum saturate
   function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] r);
      if (int'(r) > MAX_TILE_SIZE) return SIZE_W'(MAX_TILE_SIZE);
      else return SIZE_W'(r);
   endfunction

   logic [SIZE_W-1:0] tw, th;
   logic              narrow;

   assign tw     = eff_size(tile_width_ff);
   assign th     = eff_size(tile_height_ff);
   assign narrow = (int'(tw) < MIN_TILE_SIZE) || (int'(th) < MIN_TILE_SIZE);

   // ---------------------------------------------------------------
   // Stage enables: a stage loads when it is empty or the next one loads
   // ---------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_type_ff, s2_type_ff, s3_type_ff;
   logic en1, en2, en3, en4;
   pipe_en_type map_en;

   assign en4 = !rsp_valid_ff || !rsp_stall;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign map_en.st2 = en2;
   assign map_en.st3 = en3;

   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) rsp_valid_ff <= s3_valid_ff && (s3_type_ff == REQ_FETCH);
      end
   end

   // ---------------------------------------------------------------
   // Payload pipeline (raw coordinates ride along for loads)
   // ---------------------------------------------------------------
   logic [POS_W-1:0] s1_x_ff, s2_x_ff, s3_x_ff;
   logic [POS_W-1:0] s1_y_ff, s2_y_ff, s3_y_ff;
   logic [PIX_W-1:0] s1_pix_ff, s2_pix_ff, s3_pix_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_type_ff <= req_type;
         s1_x_ff    <= req_pos_x;
         s1_y_ff    <= req_pos_y;
         s1_pix_ff  <= req_pixel_in;
      end
      if (en2) begin
         s2_type_ff <= s1_type_ff;
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_pix_ff  <= s1_pix_ff;
      end
      if (en3) begin
         s3_type_ff <= s2_type_ff;
         s3_x_ff    <= s2_x_ff;
         s3_y_ff    <= s2_y_ff;
         s3_pix_ff  <= s2_pix_ff;
      end
   end

   // ---------------------------------------------------------------
   // Coordinate mapping, one unit per axis (stages 2 and 3)
   // ---------------------------------------------------------------
   logic [SRC_W-1:0] src_x, src_y;
   logic             inr_x, inr_y, in_image;

   tgr_coord_map u_map_x (
      .clock    (clock),
      .en       (map_en),
      .pos      (s1_x_ff),
      .size     (tw),
      .src      (src_x),
      .in_range (inr_x)
   );

   tgr_coord_map u_map_y (
      .clock    (clock),
      .en       (map_en),
      .pos      (s1_y_ff),
      .size     (th),
      .src      (src_y),
      .in_range (inr_y)
   );

   assign in_image = inr_x && inr_y;

   // ---------------------------------------------------------------
   // Source atlas RAM: write for loads, read for fetches, both as the
   // item leaves stage 3
   // ---------------------------------------------------------------
   logic [PIX_W-1:0]  atlas [0:STORE_DEPTH-1];
   logic [PIX_W-1:0]  rd_ff;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic              mem_we;

   assign wr_addr = ADDR_W'(s3_y_ff) * ADDR_W'(PITCH) + ADDR_W'(s3_x_ff);
   assign rd_addr = ADDR_W'(src_y) * ADDR_W'(PITCH) + ADDR_W'(src_x);
   assign mem_we  = en4 && s3_valid_ff && (s3_type_ff == REQ_LOAD) && in_image;

   always_ff @(posedge clock) begin
      if (mem_we) atlas[wr_addr] <= s3_pix_ff;
      if (en4)    rd_ff <= atlas[rd_addr];
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   logic out_bad_ff, out_zero_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         out_bad_ff  <= !in_image;
         out_zero_ff <= !in_image || narrow;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bad_coord = out_bad_ff;
   assign rsp_pixel_out = out_zero_ff ? '0 : rd_ff;

endmodule

/* design/tgr_checker.sv */
module tgr_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [tgr_pkg::PIX_W-1:0]      rsp_pixel_out,
   input  logic                           rsp_bad_coord
);
   import tgr_pkg::*;

   // no result in the cycle after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an out-of-image result always carries a zero pixel
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_coord |-> rsp_pixel_out == '0)
      else $error("bad_coord with nonzero pixel");

   // a stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pixel_out) && $stable(rsp_bad_coord))
      else $error("result changed while stalled");

endmodule

bind tile_gutter_resampler_unit tgr_checker u_tgr_checker (.*);
